[src/mcbq_pkg.sv]
package mcbq_pkg;

  // Queue geometry
  localparam int CHANNELS    = 128;
  localparam int QUEUE_DEPTH = 1024;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = $clog2(CHANNELS * QUEUE_DEPTH);
  localparam int WORDS  = CHANNELS * QUEUE_DEPTH;

  // Request field widths
  localparam int CMD_W  = 3;
  localparam int CHAN_W = 7;
  localparam int BYTE_W = 8;

  // Width used to compare a channel number against the channel count
  localparam int CHAN_CMP_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND_PUSH = 3'd0,
    CMD_SEND_PEEK = 3'd1,
    CMD_SEND_ADV  = 3'd2,
    CMD_RECV_PUSH = 3'd3,
    CMD_RECV_POP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_REPLY
  } state_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic load;    // capture request, read pointer memories
    logic access;  // store read/write, pointer update
    logic finish;  // register result
  } ctrl_cmd_t;

  // One ring's pointers as kept in the pointer memory
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } ring_ptr_t;

  // Advance a ring pointer with wrap at the queue depth
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage

[src/multi_channel_byte_queue_unit.sv]
// Channel   Handshake            Fields
// request   start / busy         command[2:0], channel[6:0], data[7:0]
// result    done (1-cycle pulse) byte_out[7:0], was_empty, more_left
//
// A request runs through pointer memory read, store access with pointer update
// and result register, in that order, as the registered reads of the pointer
// memory and of the byte store call for. done pulses in the cycle that busy drops.
// Reset (rst, synchronous) clears the controller and the per-channel pointer
// valid bits, so all rings start empty with no clearing pass; busy is held
// high while rst is asserted.
// The result receiver cannot stall; each result shows for exactly one cycle.
module multi_channel_byte_queue_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mcbq_pkg::CMD_W-1:0]   command,
  input  logic [mcbq_pkg::CHAN_W-1:0]  channel,
  input  logic [mcbq_pkg::BYTE_W-1:0]  data,
  output logic                         done,
  output logic [mcbq_pkg::BYTE_W-1:0]  byte_out,
  output logic                         was_empty,
  output logic                         more_left
);
  import mcbq_pkg::*;

  ctrl_cmd_t ctl;

  mcbq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  mcbq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .command   (command),
    .channel   (channel),
    .data      (data),
    .done      (done),
    .byte_out  (byte_out),
    .was_empty (was_empty),
    .more_left (more_left)
  );

endmodule

[src/mcbq_ctrl.sv]
module mcbq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output mcbq_pkg::ctrl_cmd_t ctl
);
  import mcbq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        busy = rst;
        if (start && !rst) begin
          ctl.load   = 1'b1;
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        ctl.access = 1'b1;
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencing checks
  a_load_then_access: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> ctl.access) else $error("access did not follow load");
  a_access_then_finish: assert property (@(posedge clk) disable iff (rst)
    ctl.access |=> ctl.finish) else $error("finish did not follow access");
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.access, ctl.finish})) else $error("strobes overlap");
  a_busy_blocks_load: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctl.load) else $error("load while busy");

endmodule

[src/mcbq_datapath.sv]
module mcbq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mcbq_pkg::ctrl_cmd_t          ctl,
  input  logic [mcbq_pkg::CMD_W-1:0]   command,
  input  logic [mcbq_pkg::CHAN_W-1:0]  channel,
  input  logic [mcbq_pkg::BYTE_W-1:0]  data,
  output logic                         done,
  output logic [mcbq_pkg::BYTE_W-1:0]  byte_out,
  output logic                         was_empty,
  output logic                         more_left
);
  import mcbq_pkg::*;

  // Captured request
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] data_r;
  logic [CH_W-1:0]   idx_r;
  logic [ADDR_W-1:0] base_r;
  logic              chan_ok_r;

  logic [CH_W-1:0]   idx_in;

  // Pointer memories, one word per channel, plus reset-cleared valid bits
  ring_ptr_t         send_ptr_mem [0:CHANNELS-1];
  ring_ptr_t         recv_ptr_mem [0:CHANNELS-1];
  logic [CHANNELS-1:0] send_vld;
  logic [CHANNELS-1:0] recv_vld;
  ring_ptr_t         send_ptr_q;
  ring_ptr_t         recv_ptr_q;
  logic              send_vld_q;
  logic              recv_vld_q;

  // Byte stores
  logic [BYTE_W-1:0] send_store [0:WORDS-1];
  logic [BYTE_W-1:0] recv_store [0:WORDS-1];
  logic [BYTE_W-1:0] send_rd;
  logic [BYTE_W-1:0] recv_rd;

  // Access-cycle decode
  ring_ptr_t         s_ptr;
  ring_ptr_t         r_ptr;
  logic              s_empty;
  logic              r_empty;
  logic              send_wr_en;
  logic              recv_wr_en;
  logic              send_ptr_we;
  logic              recv_ptr_we;
  ring_ptr_t         send_ptr_new;
  ring_ptr_t         recv_ptr_new;
  logic              use_send_next;
  logic              use_recv_next;
  logic              empty_next;
  logic              more_next;
  logic [ADDR_W-1:0] send_wr_addr;
  logic [ADDR_W-1:0] send_rd_addr;
  logic [ADDR_W-1:0] recv_wr_addr;
  logic [ADDR_W-1:0] recv_rd_addr;

  // Result held between access and reply
  logic              use_send;
  logic              use_recv;
  logic              res_empty;
  logic              res_more;

  assign idx_in = CH_W'(channel);

  // Request capture and per-channel base address
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= cmd_t'(command);
      data_r    <= data;
      idx_r     <= idx_in;
      base_r    <= ADDR_W'(idx_in) * ADDR_W'(QUEUE_DEPTH);
      chan_ok_r <= (CHAN_CMP_W'(channel) < CHAN_CMP_W'(CHANNELS));
    end
  end

  // Pointer memory read (registered)
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      send_ptr_q <= send_ptr_mem[idx_in];
      recv_ptr_q <= recv_ptr_mem[idx_in];
      send_vld_q <= send_vld[idx_in];
      recv_vld_q <= recv_vld[idx_in];
    end
  end

  // Pointer memory write
  always_ff @(posedge clk) begin
    if (ctl.access && send_ptr_we) send_ptr_mem[idx_r] <= send_ptr_new;
    if (ctl.access && recv_ptr_we) recv_ptr_mem[idx_r] <= recv_ptr_new;
  end

  // Valid bits: an unwritten channel reads as all-zero pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      send_vld <= '0;
      recv_vld <= '0;
    end else if (ctl.access) begin
      if (send_ptr_we) send_vld[idx_r] <= 1'b1;
      if (recv_ptr_we) recv_vld[idx_r] <= 1'b1;
    end
  end

  // Command decode for the access cycle
  always_comb begin
    s_ptr         = send_vld_q ? send_ptr_q : '0;
    r_ptr         = recv_vld_q ? recv_ptr_q : '0;
    s_empty       = (s_ptr.head == s_ptr.tail);
    r_empty       = (r_ptr.head == r_ptr.tail);
    send_wr_en    = 1'b0;
    recv_wr_en    = 1'b0;
    send_ptr_we   = 1'b0;
    recv_ptr_we   = 1'b0;
    send_ptr_new  = s_ptr;
    recv_ptr_new  = r_ptr;
    use_send_next = 1'b0;
    use_recv_next = 1'b0;
    empty_next    = 1'b0;
    more_next     = 1'b0;
    unique case (cmd_r)
      CMD_SEND_PUSH: begin
        if (chan_ok_r) begin
          send_wr_en        = 1'b1;
          send_ptr_we       = 1'b1;
          send_ptr_new.tail = bump(s_ptr.tail);
        end
      end
      CMD_SEND_PEEK: begin
        if (!chan_ok_r || s_empty) empty_next = 1'b1;
        else use_send_next = 1'b1;
      end
      CMD_SEND_ADV: begin
        if (!chan_ok_r || s_empty) begin
          empty_next = 1'b1;
        end else begin
          send_ptr_we       = 1'b1;
          send_ptr_new.head = bump(s_ptr.head);
          more_next         = (bump(s_ptr.head) != s_ptr.tail);
        end
      end
      CMD_RECV_PUSH: begin
        if (chan_ok_r) begin
          recv_wr_en        = 1'b1;
          recv_ptr_we       = 1'b1;
          recv_ptr_new.tail = bump(r_ptr.tail);
        end
      end
      CMD_RECV_POP: begin
        if (!chan_ok_r || r_empty) begin
          empty_next = 1'b1;
        end else begin
          use_recv_next     = 1'b1;
          recv_ptr_we       = 1'b1;
          recv_ptr_new.head = bump(r_ptr.head);
        end
      end
      default: begin
        // unused command codes: no change, all-zero result
      end
    endcase
  end

  assign send_wr_addr = base_r + ADDR_W'(s_ptr.tail);
  assign send_rd_addr = base_r + ADDR_W'(s_ptr.head);
  assign recv_wr_addr = base_r + ADDR_W'(r_ptr.tail);
  assign recv_rd_addr = base_r + ADDR_W'(r_ptr.head);

  // Send store: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctl.access) begin
      if (send_wr_en) send_store[send_wr_addr] <= data_r;
      send_rd <= send_store[send_rd_addr];
    end
  end

  // Receive store: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctl.access) begin
      if (recv_wr_en) recv_store[recv_wr_addr] <= data_r;
      recv_rd <= recv_store[recv_rd_addr];
    end
  end

  // Result flags held until the reply cycle
  always_ff @(posedge clk) begin
    if (ctl.access) begin
      use_send  <= use_send_next;
      use_recv  <= use_recv_next;
      res_empty <= empty_next;
      res_more  <= more_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      priority if (use_send) byte_out <= send_rd;
      else if (use_recv) byte_out <= recv_rd;
      else byte_out <= '0;
      was_empty <= res_empty;
      more_left <= res_more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ctl.finish;
  end

  // Result checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.finish)) else $error("result without finish");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_empty && more_left)) else $error("empty and more both set");
  a_empty_no_byte: assert property (@(posedge clk) disable iff (rst)
    (done && was_empty) |-> (byte_out == '0)) else $error("byte on empty ring");
  a_one_byte_source: assert property (@(posedge clk) disable iff (rst)
    ctl.access |=> !(use_send && use_recv)) else $error("two byte sources");

endmodule

[tb/multi_channel_byte_queue_unit_test.sv]
`timescale 1ns / 1ps

module multi_channel_byte_queue_unit_test;
  import mcbq_pkg::*;

  // Codes the block must treat as no-ops
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_REQUESTS = 650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              was_empty;
    logic              more_left;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [CHAN_W-1:0] ch;
    logic [BYTE_W-1:0] dat;
    logic              typed;  // reply below is fixed by hand
    reply_t            want;
  } request_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic [CHAN_W-1:0] channel = '0;
  logic [BYTE_W-1:0] data = '0;
  logic done;
  logic [BYTE_W-1:0] byte_out;
  logic was_empty;
  logic more_left;

  multi_channel_byte_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .channel(channel),
    .data(data),
    .done(done),
    .byte_out(byte_out),
    .was_empty(was_empty),
    .more_left(more_left)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the rings
  logic [BYTE_W-1:0] send_bytes [CHANNELS][QUEUE_DEPTH];
  logic [BYTE_W-1:0] recv_bytes [CHANNELS][QUEUE_DEPTH];
  logic [PTR_W-1:0]  send_rd [CHANNELS];
  logic [PTR_W-1:0]  send_wr [CHANNELS];
  logic [PTR_W-1:0]  recv_rd [CHANNELS];
  logic [PTR_W-1:0]  recv_wr [CHANNELS];

  reply_t pending_replies [$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 20;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one request to the shadow rings and returns the reply it should give
  function automatic reply_t predict_ring_access(input logic [CMD_W-1:0] op,
                                                 input logic [CHAN_W-1:0] ch,
                                                 input logic [BYTE_W-1:0] dat);
    reply_t r;
    int c;
    r = '0;
    c = int'(ch);
    if (op > CMD_RECV_POP) return r;
    if (c >= CHANNELS) begin
      // out-of-range channel: reads look empty, pushes are dropped
      r.was_empty = (op == CMD_SEND_PEEK || op == CMD_SEND_ADV || op == CMD_RECV_POP);
      return r;
    end
    case (op)
      CMD_SEND_PUSH: begin
        send_bytes[c][send_wr[c]] = dat;
        send_wr[c] = ring_next(send_wr[c]);
      end
      CMD_SEND_PEEK: begin
        if (send_rd[c] == send_wr[c]) r.was_empty = 1'b1;
        else r.byte_out = send_bytes[c][send_rd[c]];
      end
      CMD_SEND_ADV: begin
        if (send_rd[c] == send_wr[c]) begin
          r.was_empty = 1'b1;
        end else begin
          send_rd[c] = ring_next(send_rd[c]);
          r.more_left = (send_rd[c] != send_wr[c]);
        end
      end
      CMD_RECV_PUSH: begin
        recv_bytes[c][recv_wr[c]] = dat;
        recv_wr[c] = ring_next(recv_wr[c]);
      end
      default: begin
        if (recv_rd[c] == recv_wr[c]) begin
          r.was_empty = 1'b1;
        end else begin
          r.byte_out = recv_bytes[c][recv_rd[c]];
          recv_rd[c] = ring_next(recv_rd[c]);
        end
      end
    endcase
    return r;
  endfunction

  // Optional gap, then hold the request until it is taken; start stays high
  // on return so back-to-back requests need no second assignment
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [CHAN_W-1:0] ch,
                              input logic [BYTE_W-1:0] dat, input logic typed,
                              input reply_t want);
    reply_t got;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    command <= op;
    channel <= ch;
    data <= dat;
    do @(posedge clk); while (busy);
    got = predict_ring_access(op, ch, dat);
    pending_replies.push_back(typed ? want : got);
  endtask

  // Result checker: every done pulse must match the oldest expectation
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result with no request outstanding: byte_out %0h was_empty %0b more_left %0b",
               byte_out, was_empty, more_left);
        mismatches++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (byte_out !== exp_r.byte_out) begin
          $error("byte_out: expected %0h, got %0h", exp_r.byte_out, byte_out);
          mismatches++;
        end
        if (was_empty !== exp_r.was_empty) begin
          $error("was_empty: expected %0b, got %0b", exp_r.was_empty, was_empty);
          mismatches++;
        end
        if (more_left !== exp_r.more_left) begin
          $error("more_left: expected %0b, got %0b", exp_r.more_left, more_left);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  request_row_t directed_rows [DIRECTED_ROWS];
  logic [CHAN_W-1:0] hot_ch [4];

  initial begin
    logic [CMD_W-1:0] op;
    logic [CHAN_W-1:0] ch;
    int pick;
    int counted;

    for (int c = 0; c < CHANNELS; c++) begin
      send_rd[c] = '0;
      send_wr[c] = '0;
      recv_rd[c] = '0;
      recv_wr[c] = '0;
    end

    // Empty reads, extreme bytes and channels, unknown codes
    directed_rows = '{
      '{CMD_SEND_PEEK, 7'd0,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_SEND_ADV,  7'd0,   8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_RECV_POP,  7'd127, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_SEND_PUSH, 7'd0,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_SEND_PUSH, 7'd0,   8'hff, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_SEND_PEEK, 7'd0,   8'h5a, 1'b0, '0},
      '{CMD_SEND_ADV,  7'd0,   8'h00, 1'b0, '0},
      '{CMD_SEND_PEEK, 7'd0,   8'h00, 1'b0, '0},
      '{CMD_SEND_ADV,  7'd0,   8'h00, 1'b0, '0},
      '{CMD_SEND_ADV,  7'd0,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_RECV_PUSH, 7'd127, 8'ha5, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_RECV_PUSH, 7'd127, 8'h5a, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_RECV_POP,  7'd127, 8'hff, 1'b0, '0},
      '{CMD_RECV_POP,  7'd127, 8'h00, 1'b0, '0},
      '{CMD_RECV_POP,  7'd127, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_UNUSED_5,  7'd0,   8'hff, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_UNUSED_6,  7'd127, 8'h55, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_UNUSED_7,  7'd42,  8'haa, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_SEND_PUSH, 7'd127, 8'h81, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_RECV_PUSH, 7'd0,   8'h7e, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_SEND_PEEK, 7'd127, 8'h00, 1'b0, '0},
      '{CMD_RECV_POP,  7'd0,   8'h00, 1'b0, '0},
      '{CMD_SEND_PEEK, 7'd0,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].dat,
                   directed_rows[i].typed, directed_rows[i].want);

    // Send ring wrap: fill to one short of full, peek, then the push that makes
    // it look empty, then reuse
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == QUEUE_DEPTH - 1) send_request(CMD_SEND_PEEK, 7'd64, 8'h00, 1'b0, '0);
      send_request(CMD_SEND_PUSH, 7'd64, 8'($urandom), 1'b0, '0);
    end
    send_request(CMD_SEND_PEEK, 7'd64, 8'h00, 1'b0, '0);
    send_request(CMD_SEND_ADV,  7'd64, 8'h00, 1'b0, '0);
    send_request(CMD_SEND_PUSH, 7'd64, 8'h3c, 1'b0, '0);
    send_request(CMD_SEND_PEEK, 7'd64, 8'h00, 1'b0, '0);
    send_request(CMD_SEND_ADV,  7'd64, 8'h00, 1'b0, '0);

    // Receive ring wrap: fill until it looks empty, with no read at one short of full, then reuse
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(CMD_RECV_PUSH, 7'd65, 8'($urandom), 1'b0, '0);
    send_request(CMD_RECV_POP,  7'd65, 8'h00, 1'b0, '0);
    send_request(CMD_RECV_PUSH, 7'd65, 8'hc3, 1'b0, '0);
    send_request(CMD_RECV_POP,  7'd65, 8'h00, 1'b0, '0);

    // Random traffic, mostly on a few busy channels so the rings fill up
    for (int k = 0; k < 4; k++) hot_ch[k] = 7'($urandom_range(0, CHANNELS - 1));
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      if (counted < RANDOM_REQUESTS / 3) idle_pct = 20;
      else if (counted < 2 * RANDOM_REQUESTS / 3) idle_pct = 50;
      else idle_pct = 0;
      ch = ($urandom_range(99) < 85) ? hot_ch[$urandom_range(0, 3)] : 7'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) op = CMD_SEND_PUSH;
      else if (pick < 42) op = CMD_SEND_PEEK;
      else if (pick < 57) op = CMD_SEND_ADV;
      else if (pick < 77) op = CMD_RECV_PUSH;
      else if (pick < 95) op = CMD_RECV_POP;
      else op = CMD_UNUSED_5 + 3'($urandom_range(0, 2));
      send_request(op, ch, 8'($urandom), 1'b0, '0);
      if (op <= CMD_RECV_POP) counted++;
    end

    // Drain
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
